// File: rtl/core/lsphd_pkg.sv
// Shared types and constants for the LED spectrum peak-hold display core.
// Used by every module in rtl/core; depends on nothing else.
`timescale 1ns / 1ps

package lsphd_pkg;

    // Field widths of the stream words
    localparam int CHAN_W   = 4;
    localparam int STR_W    = 8;
    localparam int LVL_W    = 7;
    localparam int PHASE_W  = 4;
    localparam int MASK_W   = 13;
    localparam int SWEEP_W  = 3;

    // Display timing and register reset value
    localparam logic [PHASE_W-1:0] DISPLAY_PHASES = 4'd12;
    localparam logic [STR_W-1:0]   FLOOR_RESET    = 8'hE2;

    // Command codes on the input tuser
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // Result kinds on the output tuser
    localparam logic KIND_LED = 1'b0;
    localparam logic KIND_REQ = 1'b1;

    // One input word
    typedef struct packed {
        logic              command;
        logic [CHAN_W-1:0] channel_index;
        logic [STR_W-1:0]  strength;
        logic              last_sample;
    } t_in_item;

    // One result word
    typedef struct packed {
        logic               kind;
        logic [MASK_W-1:0]  led_mask;
        logic [SWEEP_W-1:0] sweep_offset;
    } t_result;

    // Level bank controls for the item being processed
    typedef struct packed {
        logic              upd_en;
        logic [CHAN_W-1:0] upd_ch;
        logic [LVL_W-1:0]  upd_val;
        logic              decay;
    } t_lvl_ctl;

endpackage

// File: rtl/core/lsphd_in_reg.sv
// Input register stage: holds one accepted word until the core consumes it.
// Depends on lsphd_pkg for the item type.
`timescale 1ns / 1ps

module lsphd_in_reg (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  lsphd_pkg::t_in_item i_item,
    output logic               o_valid,
    input  logic               i_take,
    output lsphd_pkg::t_in_item o_item
);
    import lsphd_pkg::*;

    logic     r_valid;
    t_in_item r_item;

    // The stage refills in the same cycle that its word is consumed.
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item <= i_item;
        end
    end

endmodule

// File: rtl/core/lsphd_levels.sv
// Per-channel peak-held levels with max update, decay and LED mask compare.
// Depends on lsphd_pkg for widths, the display phase count and control struct.
`timescale 1ns / 1ps

module lsphd_levels #(
    parameter int NUM_CHANNELS = 13
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  lsphd_pkg::t_lvl_ctl               i_ctl,
    input  logic [lsphd_pkg::PHASE_W-1:0]     i_phase,
    output logic [lsphd_pkg::MASK_W-1:0]      o_mask
);
    import lsphd_pkg::*;

    localparam int CH_SPAN = 1 << CHAN_W;

    logic [LVL_W-1:0] r_lvl [NUM_CHANNELS];

    // Each channel raises to the sample value if addressed and higher, then decays by one on a decay request.
    for (genvar k = 0; k < NUM_CHANNELS; k++) begin : g_chan
        logic             hit;
        logic [LVL_W-1:0] raised;
        logic [LVL_W-1:0] n_lvl;

        if (k < CH_SPAN) begin : g_addr
            assign hit = i_ctl.upd_en && (i_ctl.upd_ch == CHAN_W'(k));
        end else begin : g_noaddr
            assign hit = 1'b0;
        end

        always_comb begin
            raised = (hit && (i_ctl.upd_val > r_lvl[k])) ? i_ctl.upd_val : r_lvl[k];
            n_lvl  = (i_ctl.decay && (raised != '0)) ? raised - LVL_W'(1) : raised;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_lvl[k] <= '0;
            end else begin
                r_lvl[k] <= n_lvl;
            end
        end
    end

    // Even LEDs compare against the phase, odd LEDs against its mirror.
    for (genvar j = 0; j < MASK_W; j++) begin : g_led
        if (j < NUM_CHANNELS) begin : g_lit
            logic [PHASE_W-1:0] thr;
            assign thr       = (j % 2 == 1) ? (DISPLAY_PHASES - i_phase) : i_phase;
            assign o_mask[j] = r_lvl[j] > {{(LVL_W-PHASE_W){1'b0}}, thr};
        end else begin : g_dark
            assign o_mask[j] = 1'b0;
        end
    end

endmodule

// File: rtl/core/lsphd_out_reg.sv
// Output register stage: holds one result word until the receiver takes it.
// Depends on lsphd_pkg for the result type.
`timescale 1ns / 1ps

module lsphd_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lsphd_pkg::t_result i_result,
    output logic              o_valid,
    input  logic              i_ready,
    output lsphd_pkg::t_result o_result
);
    import lsphd_pkg::*;

    logic    r_valid;
    t_result r_result;

    // A new result may load in the same cycle that the old one leaves.
    assign o_ready  = !r_valid || i_ready;
    assign o_valid  = r_valid;
    assign o_result = r_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_result <= i_result;
        end
    end

endmodule

// File: rtl/core/led_spectrum_peak_hold_display_core.sv
// LED spectrum peak-hold display core: top level.
// Instantiates lsphd_in_reg, lsphd_levels and lsphd_out_reg; uses lsphd_pkg.
//
// Usage:
//   Input stream (s_axis_*): tuser is the command (0 display tick, 1 sample),
//   tdata carries channel index and signed strength, tlast marks the last
//   sample of a sweep. Output stream (m_axis_*): tuser is the kind (0 LED
//   pattern, 1 measurement request), tdata carries the LED mask and sweep
//   offset. Samples produce no output word; every tick produces one.
//   The noise floor register is written through i_cfg_valid/o_cfg_ready and
//   i_cfg_data; the user must write it only while the core is idle, which
//   the block itself does not enforce. Throughput is one word per clock while
//   the output register has room. A tick word waits in the input register,
//   where the level compare builds its result, until the output register loads it.
//   Reset (synchronous, active low) clears all levels, the phase and the
//   sweep offset, empties both registers and sets the floor to -30.
//   When the receiver stalls, the result waits in the output register while
//   one more word waits in the input register; after that s_axis_tready drops
//   until the output register frees. Samples still drain during a stall.
`timescale 1ns / 1ps

module led_spectrum_peak_hold_display_core #(
    parameter int NUM_CHANNELS = 13,
    parameter int OFFSET_STEPS = 5
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // noise_floor (signed)
    // Input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [3:0] channel_index, [11:4] strength, [15:12] zero
    input  logic        s_axis_tuser,   // [0] command
    input  logic        s_axis_tlast,   // last_sample
    // Output stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [12:0] led_mask, [15:13] sweep_offset
    output logic        m_axis_tuser    // [0] kind
);
    import lsphd_pkg::*;

    localparam int OFF_W = (OFFSET_STEPS > 1) ? $clog2(OFFSET_STEPS) : 1;

    t_in_item             in_item;
    t_in_item             cur;
    logic                 cur_valid;
    logic                 take;
    logic                 is_tick;
    logic                 is_sample;
    logic                 out_ready;
    t_result              res;
    t_result              out_res;
    t_lvl_ctl             lvl_ctl;
    logic [MASK_W-1:0]    mask;
    logic [STR_W:0]       excess;
    logic [OFF_W+2:0]     off_ext;

    logic [STR_W-1:0]     r_floor;
    logic [PHASE_W-1:0]   r_phase;
    logic [PHASE_W-1:0]   n_phase;
    logic [OFF_W-1:0]     r_off;
    logic [OFF_W-1:0]     n_off;

    // Noise floor register, always ready.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_floor <= FLOOR_RESET;
        end else if (i_cfg_valid) begin
            r_floor <= i_cfg_data;
        end
    end

    // Unpack the input word.
    always_comb begin
        in_item.command       = s_axis_tuser;
        in_item.channel_index = s_axis_tdata[3:0];
        in_item.strength      = s_axis_tdata[11:4];
        in_item.last_sample   = s_axis_tlast;
    end

    lsphd_in_reg u_in_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_item  (in_item),
        .o_valid (cur_valid),
        .i_take  (take),
        .o_item  (cur)
    );

    // A tick needs room in the output register; a sample always drains.
    assign is_tick   = cur_valid && (cur.command == CMD_TICK);
    assign is_sample = cur_valid && (cur.command == CMD_SAMPLE);
    assign take      = is_sample || (is_tick && out_ready);

    // Excess over the floor, sign-extended to nine bits.
    assign excess = {cur.strength[STR_W-1], cur.strength} - {r_floor[STR_W-1], r_floor};

    always_comb begin
        lvl_ctl.upd_en  = is_sample && !excess[STR_W] && (excess != '0);
        lvl_ctl.upd_ch  = cur.channel_index;
        lvl_ctl.upd_val = excess[LVL_W:1];
        lvl_ctl.decay   = is_sample && cur.last_sample;
    end

    lsphd_levels #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_levels (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (lvl_ctl),
        .i_phase (r_phase),
        .o_mask  (mask)
    );

    // Phase and sweep offset sequencing.
    always_comb begin
        n_phase = r_phase;
        n_off   = r_off;
        if (take && is_tick && (r_phase < DISPLAY_PHASES)) begin
            n_phase = r_phase + PHASE_W'(1);
        end
        if (lvl_ctl.decay) begin
            n_phase = '0;
            if ({1'b0, r_off} + (OFF_W+1)'(1) >= (OFF_W+1)'(OFFSET_STEPS)) begin
                n_off = '0;
            end else begin
                n_off = r_off + OFF_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_off   <= '0;
        end else begin
            r_phase <= n_phase;
            r_off   <= n_off;
        end
    end

    // Build the result word for a tick.
    assign off_ext = {3'b000, r_off};

    always_comb begin
        if (r_phase < DISPLAY_PHASES) begin
            res.kind         = KIND_LED;
            res.led_mask     = mask;
            res.sweep_offset = '0;
        end else begin
            res.kind         = KIND_REQ;
            res.led_mask     = '0;
            res.sweep_offset = off_ext[SWEEP_W-1:0];
        end
    end

    lsphd_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (is_tick),
        .o_ready  (out_ready),
        .i_result (res),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_result (out_res)
    );

    // Pack the output word.
    assign m_axis_tdata = {out_res.sweep_offset, out_res.led_mask};
    assign m_axis_tuser = out_res.kind;

endmodule

// File: tb/tb_led_spectrum_peak_hold_display_core.sv
// Self-checking testbench for the LED spectrum peak-hold display core.
// Drives ticks and samples, predicts every LED or request word and compares;
// depends on lsphd_pkg and led_spectrum_peak_hold_display_core.
`timescale 1ns / 1ps

module tb_led_spectrum_peak_hold_display_core;

    import lsphd_pkg::*;

    localparam int NUM_CH       = 13;
    localparam int OFFSET_STEPS = 5;
    localparam int PHASE_ITEMS  = 225;

    // Clock, reset and block ports
    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data    = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = 16'd0;
    logic        s_axis_tuser  = 1'b0;
    logic        s_axis_tlast  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        m_axis_tuser;

    led_spectrum_peak_hold_display_core #(
        .NUM_CHANNELS (NUM_CH),
        .OFFSET_STEPS (OFFSET_STEPS)
    ) u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 i_clk = ~i_clk;

    // Words waiting to be sent and display words waiting to be seen
    t_in_item pending_words[$];
    t_result  expected_display[$];
    t_in_item cur_word;
    int       words_queued   = 0;
    int       words_accepted = 0;
    int       mismatch_count = 0;
    int       send_idle_pct  = 0;
    int       stall_pct      = 0;
    logic     hold_active    = 1'b0;

    // Shadow copy of the display state
    logic [LVL_W-1:0]          level_q [NUM_CH];
    logic [PHASE_W-1:0]        phase_q  = '0;
    logic [SWEEP_W-1:0]        offset_q = '0;
    logic signed [STR_W-1:0]   floor_q  = FLOOR_RESET;

    // Apply one accepted word to the shadow state; returns 1 when it yields a display word.
    function automatic bit update_display(input t_in_item w, output t_result res);
        int diff;
        int thr;
        res = '0;
        if (w.command == CMD_TICK) begin
            if (phase_q < DISPLAY_PHASES) begin
                res.kind = KIND_LED;
                for (int k = 0; k < NUM_CH; k++) begin
                    thr = (k % 2 == 1) ? int'(DISPLAY_PHASES) - int'(phase_q) : int'(phase_q);
                    if (int'(level_q[k]) > thr)
                        res.led_mask[k] = 1'b1;
                end
                phase_q = phase_q + 1'b1;
            end else begin
                res.kind         = KIND_REQ;
                res.sweep_offset = offset_q;
            end
            return 1'b1;
        end
        // A sample raises its level to half the excess over the floor.
        diff = int'($signed(w.strength)) - int'(floor_q);
        if (w.channel_index < NUM_CH && diff > 0) begin
            if ((diff >> 1) > int'(level_q[w.channel_index]))
                level_q[w.channel_index] = LVL_W'(diff >> 1);
        end
        // The last sample of a sweep decays all levels and restarts the display.
        if (w.last_sample) begin
            for (int k = 0; k < NUM_CH; k++)
                if (level_q[k] != 0)
                    level_q[k] = level_q[k] - 1'b1;
            phase_q  = '0;
            offset_q = (int'(offset_q) + 1 >= OFFSET_STEPS) ? '0 : offset_q + 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic void note_mismatch(input string what, input t_result want,
                                          input t_result got);
        if (mismatch_count < 10)
            $display("%0t: %s: expected kind %0d mask %04h offset %0d,",
                     $time, what, want.kind, want.led_mask, want.sweep_offset,
                     " got kind %0d mask %04h offset %0d",
                     got.kind, got.led_mask, got.sweep_offset);
        mismatch_count++;
    endfunction

    // Input driver: predicts each word on acceptance, then offers the next one.
    always @(posedge i_clk) begin : word_driver
        t_result res;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (update_display(cur_word, res))
                    expected_display.push_back(res);
                words_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    cur_word = pending_words.pop_front();
                    s_axis_tdata  <= {4'b0000, cur_word.strength, cur_word.channel_index};
                    s_axis_tuser  <= cur_word.command;
                    s_axis_tlast  <= cur_word.last_sample;
                    s_axis_tvalid <= 1'b1;
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output monitor: checks each accepted display word and drives backpressure.
    always @(posedge i_clk) begin : display_monitor
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got.kind         = m_axis_tuser;
                got.led_mask     = m_axis_tdata[12:0];
                got.sweep_offset = m_axis_tdata[15:13];
                if (expected_display.size() == 0) begin
                    note_mismatch("unexpected word", '0, got);
                end else begin
                    want = expected_display.pop_front();
                    if (got.kind !== want.kind || got.led_mask !== want.led_mask ||
                        got.sweep_offset !== want.sweep_offset)
                        note_mismatch("wrong word", want, got);
                end
            end
            m_axis_tready <= !hold_active && ($urandom_range(99) >= stall_pct);
        end
    end

    // Long receiver hold-off early in the first phase, so the input side fills up.
    initial begin
        wait (i_rst_n);
        repeat (60) @(posedge i_clk);
        hold_active <= 1'b1;
        repeat (300) @(posedge i_clk);
        hold_active <= 1'b0;
    end

    // Run limit.
    initial begin
        #400000;
        $display("led_spectrum_peak_hold_display_core test failed");
        $finish;
    end

    task automatic push_word(input logic cmd, input int ch, input int strength,
                             input logic last);
        t_in_item w;
        w.command       = cmd;
        w.channel_index = CHAN_W'(ch);
        w.strength      = STR_W'(strength);
        w.last_sample   = last;
        pending_words.push_back(w);
        words_queued++;
    endtask

    // One display sweep: ticks through the phases, then a sample per channel.
    task automatic queue_sweep();
        int n_ticks;
        int ch;
        n_ticks = ($urandom_range(9) == 0) ? $urandom_range(11) : 12 + $urandom_range(2);
        for (int i = 0; i < n_ticks; i++)
            push_word(CMD_TICK, $urandom_range(15), $urandom_range(255),
                      1'($urandom_range(1)));
        for (int i = 0; i < NUM_CH; i++) begin
            ch = ($urandom_range(5) == 0) ? $urandom_range(15) : i;
            push_word(CMD_SAMPLE, ch, $urandom_range(255), i == NUM_CH - 1);
        end
    endtask

    // A few words with fully random fields.
    task automatic queue_noise();
        repeat ($urandom_range(1, 6))
            push_word(1'($urandom_range(1)), $urandom_range(15), $urandom_range(255),
                      $urandom_range(7) == 0);
    endtask

    // Wait until every word is in and every display word is out, then let the pipe drain.
    task automatic wait_idle();
        while (words_accepted != words_queued || expected_display.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_floor(input logic [7:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        floor_q = value;
        i_cfg_valid <= 1'b0;
    endtask

    // Stimulus: directed words at reset settings, then random phases with varied idling.
    initial begin : stimulus
        int          start_count;
        logic [7:0]  floors [4];
        int          send_pcts [5];
        int          stall_pcts [5];
        floors     = '{8'h80, 8'h7F, 8'h00, 8'h00};
        floors[3]  = 8'($urandom_range(255));
        send_pcts  = '{0, 45, 0, 17, 0};
        stall_pcts = '{0, 0, 45, 17, 0};
        for (int k = 0; k < NUM_CH; k++)
            level_q[k] = '0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part with the reset floor of -30.
        push_word(CMD_TICK,   0,    0, 1'b0);   // all levels still zero
        push_word(CMD_SAMPLE, 0,  127, 1'b0);   // strongest sample
        push_word(CMD_SAMPLE, 1, -128, 1'b0);   // weakest sample, ignored
        push_word(CMD_SAMPLE, 2,  -30, 1'b0);   // exactly at the floor, ignored
        push_word(CMD_SAMPLE, 3,  -29, 1'b0);   // one above the floor gives level zero
        push_word(CMD_SAMPLE, 12, 100, 1'b0);   // highest channel
        push_word(CMD_SAMPLE, 15, 127, 1'b0);   // channel out of range
        push_word(CMD_SAMPLE, 13,  50, 1'b0);   // first channel out of range
        push_word(CMD_SAMPLE, 11, -20, 1'b0);
        push_word(CMD_SAMPLE, 5,    0, 1'b0);
        push_word(CMD_SAMPLE, 5,  -10, 1'b0);   // lower than the held peak
        for (int i = 0; i < 11; i++)
            push_word(CMD_TICK, 0, 0, 1'b0);    // remaining LED phases
        push_word(CMD_TICK, 0, 0, 1'b0);        // measurement request
        push_word(CMD_TICK, 0, 0, 1'b0);        // repeated request
        push_word(CMD_SAMPLE, 14, 127, 1'b1);   // last sample on a bad channel still ends the sweep

        for (int ph = 0; ph < 5; ph++) begin
            if (ph > 0) begin
                wait_idle();
                write_floor(floors[ph - 1]);
            end
            send_idle_pct = send_pcts[ph];
            stall_pct     = stall_pcts[ph];
            start_count   = words_queued;
            while (words_queued - start_count < PHASE_ITEMS) begin
                if ($urandom_range(4) != 0)
                    queue_sweep();
                else
                    queue_noise();
            end
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (mismatch_count == 0 && expected_display.size() == 0)
            $display("led_spectrum_peak_hold_display_core test passed");
        else
            $display("led_spectrum_peak_hold_display_core test failed");
        $finish;
    end

endmodule

// File: filelist.f
rtl/core/lsphd_pkg.sv
rtl/core/lsphd_in_reg.sv
rtl/core/lsphd_levels.sv
rtl/core/lsphd_out_reg.sv
rtl/core/led_spectrum_peak_hold_display_core.sv
tb/tb_led_spectrum_peak_hold_display_core.sv
